// ----- design/bdh_pkg.sv -----
// ----------------------------------------------------------------------------
// Button debouncer package
// Shared widths, configuration register codes, reset values and helpers.
// ----------------------------------------------------------------------------
package bdh_pkg;

  // Width of the hold counter and of the stored duration.
  localparam int CntW = 32;
  // Width of the duration fields on the result channel.
  localparam int OutW = 32;
  // Widest configuration register.
  localparam int CfgDataW = 32;
  localparam int TickW = 16;

  typedef logic [CntW-1:0] cnt_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_ACTIVE_HIGH   = 2'd0,
    CFG_TICK_INTERVAL = 2'd1,
    CFG_MIN_HOLD_TIME = 2'd2,
    CFG_MAX_COUNT     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic             active_high;
    logic [TickW-1:0] tick_interval;
    logic [31:0]      min_hold_time;
    logic [31:0]      max_count;
  } cfg_t;

  localparam logic             RstActiveHigh  = 1'b0;
  localparam logic [TickW-1:0] RstTickInterval = 16'd1;
  localparam logic [31:0]      RstMinHoldTime  = 32'd30;
  localparam logic [31:0]      RstMaxCount     = 32'd4000000000;

  // One result of the debouncer.
  typedef struct packed {
    logic            pressed;
    logic            press_event;
    logic            release_event;
    logic            change_event;
    logic            clicked;
    logic [OutW-1:0] time_in_state;
    logic [OutW-1:0] time_in_last_state;
  } result_t;

  // A 32-bit register value taken at the counter width.
  function automatic cnt_t to_cnt(logic [31:0] v);
    logic [CntW+31:0] ext;
    ext = {{CntW{1'b0}}, v};
    return ext[CntW-1:0];
  endfunction

  // A counter value taken at the output width (low bits, zero extended).
  function automatic logic [OutW-1:0] to_out(cnt_t v);
    logic [CntW+OutW-1:0] ext;
    ext = {{OutW{1'b0}}, v};
    return ext[OutW-1:0];
  endfunction

endpackage

// ----- design/bdh_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Button debouncer configuration registers
// Holds polarity, tick interval, minimum hold time and counter ceiling.
// ----------------------------------------------------------------------------
module bdh_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [bdh_pkg::CfgDataW-1:0] cfg_wdata_i,
  output bdh_pkg::cfg_t              cfg_o
);

  bdh_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_high   <= bdh_pkg::RstActiveHigh;
      cfg_q.tick_interval <= bdh_pkg::RstTickInterval;
      cfg_q.min_hold_time <= bdh_pkg::RstMinHoldTime;
      cfg_q.max_count     <= bdh_pkg::RstMaxCount;
    end else if (cfg_we_i) begin
      unique case (bdh_pkg::cfg_idx_e'(cfg_idx_i))
        bdh_pkg::CFG_ACTIVE_HIGH:   cfg_q.active_high   <= cfg_wdata_i[0];
        bdh_pkg::CFG_TICK_INTERVAL: cfg_q.tick_interval <= cfg_wdata_i[bdh_pkg::TickW-1:0];
        bdh_pkg::CFG_MIN_HOLD_TIME: cfg_q.min_hold_time <= cfg_wdata_i[31:0];
        bdh_pkg::CFG_MAX_COUNT:     cfg_q.max_count     <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/bdh_core.sv -----
// ----------------------------------------------------------------------------
// Button debouncer core
// Debounce state registers and the single-pass update for one tick.
// ----------------------------------------------------------------------------
module bdh_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bdh_pkg::cfg_t    cfg_i,
  input  logic             step_i,
  input  logic             pin_level_i,
  input  logic             clear_click_i,
  output bdh_pkg::result_t result_o
);

  localparam int SumW = ((bdh_pkg::CntW > bdh_pkg::TickW) ? bdh_pkg::CntW : bdh_pkg::TickW) + 1;
  localparam bdh_pkg::cnt_t CntMax = {bdh_pkg::CntW{1'b1}};

  logic          last_raw_q, last_raw_d;
  logic          stable_q, stable_d;
  logic          click_q, click_d;
  bdh_pkg::cnt_t hold_q, hold_d;
  bdh_pkg::cnt_t last_dur_q, last_dur_d;

  logic          raw;
  logic          same;
  logic [SumW-1:0] sum;
  bdh_pkg::cnt_t cnt_add, cnt_a, minh, ceil_v, tis;
  logic          chg, rel, click_rep;

  always_comb begin
    raw    = cfg_i.active_high ? pin_level_i : ~pin_level_i;
    same   = (raw == last_raw_q);
    minh   = bdh_pkg::to_cnt(cfg_i.min_hold_time);
    ceil_v = bdh_pkg::to_cnt(cfg_i.max_count);

    // Saturating add: never wraps past the all-ones count.
    sum = {{(SumW-bdh_pkg::CntW){1'b0}}, hold_q}
        + {{(SumW-bdh_pkg::TickW){1'b0}}, cfg_i.tick_interval};
    cnt_add = (sum[SumW-1:bdh_pkg::CntW] != '0) ? CntMax : sum[bdh_pkg::CntW-1:0];

    // A raw change restarts the count, keeping the old one if it was long enough.
    cnt_a      = same ? cnt_add : '0;
    last_dur_d = (!same && (hold_q > minh)) ? hold_q : last_dur_q;
    last_raw_d = raw;

    // The debounce compare sees the count before the ceiling clamp.
    chg       = (cnt_a >= minh) && (stable_q != raw);
    stable_d  = chg ? raw : stable_q;
    rel       = chg & ~raw;
    click_rep = click_q | rel;
    click_d   = clear_click_i ? 1'b0 : click_rep;

    hold_d = (cnt_a >= ceil_v) ? ceil_v : cnt_a;
    tis    = (hold_d > minh) ? (hold_d - minh) : '0;

    result_o.pressed            = stable_d;
    result_o.press_event        = chg & raw;
    result_o.release_event      = rel;
    result_o.change_event       = chg;
    result_o.clicked            = click_rep;
    result_o.time_in_state      = bdh_pkg::to_out(tis);
    result_o.time_in_last_state = bdh_pkg::to_out(last_dur_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= 1'b0;
      stable_q   <= 1'b0;
      click_q    <= 1'b0;
      hold_q     <= '0;
      last_dur_q <= '0;
    end else if (step_i) begin
      last_raw_q <= last_raw_d;
      stable_q   <= stable_d;
      click_q    <= click_d;
      hold_q     <= hold_d;
      last_dur_q <= last_dur_d;
    end
  end

endmodule

// ----- design/button_debouncer_with_hold_timer.sv -----
// ----------------------------------------------------------------------------
// Button debouncer with hold timer
// Counter-based debouncer reporting press, release and click events and
// the time spent in the current and previous stable levels.
// ----------------------------------------------------------------------------
// Usage: every request on the input channel is one timer tick carrying the
// sampled pin level and a request to clear the sticky click flag. Each tick
// yields exactly one result request on the output channel. The debounce
// state and the result register are updated in the same cycle the tick is
// accepted, so the block takes one tick per clock cycle while not stalled;
// its throughput is set by the single add, compare and clamp path. When the
// receiver stalls, the result is held in the output register and the input
// channel is stalled in the same cycle; as soon as the receiver takes the
// result a new tick may be accepted in that very cycle. Reset clears the
// debounce state and loads the register defaults (low level means pressed,
// interval one, minimum hold 30, ceiling 4000000000). Write the configuration
// port only while no tick is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module button_debouncer_with_hold_timer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [bdh_pkg::CfgDataW-1:0]   cfg_wdata_i,
  // Tick channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           pin_level_i,
  input  logic                           clear_click_i,
  // Result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           pressed_o,
  output logic                           press_event_o,
  output logic                           release_event_o,
  output logic                           change_event_o,
  output logic                           clicked_o,
  output logic [bdh_pkg::OutW-1:0]       time_in_state_o,
  output logic [bdh_pkg::OutW-1:0]       time_in_last_state_o
);

  bdh_pkg::cfg_t    cfg;
  bdh_pkg::result_t result;
  bdh_pkg::result_t res_q;
  logic             out_valid_q;
  logic             accept;

  // The input waits only while a result is held back by the receiver.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  bdh_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bdh_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .step_i        (accept),
    .pin_level_i   (pin_level_i),
    .clear_click_i (clear_click_i),
    .result_o      (result)
  );

  // Result register: loaded with every accepted tick, emptied when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= result;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign pressed_o            = res_q.pressed;
  assign press_event_o        = res_q.press_event;
  assign release_event_o      = res_q.release_event;
  assign change_event_o       = res_q.change_event;
  assign clicked_o            = res_q.clicked;
  assign time_in_state_o      = res_q.time_in_state;
  assign time_in_last_state_o = res_q.time_in_last_state;

  // A press or a release is always reported as a change, never both at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (change_event_o == (press_event_o | release_event_o)))
    else $error("change event does not match press and release events");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(press_event_o && release_event_o))
    else $error("press and release reported on the same tick");

  // The debounced state agrees with the event that set it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && press_event_o) |-> pressed_o)
    else $error("press event without pressed state");

  // A release always leaves the click flag set in its own result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && release_event_o) |-> (!pressed_o && clicked_o))
    else $error("release event without released state and click");

  // The input is only held off while a result is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with an empty result register");

endmodule

// ----- verif/tb_button_debouncer_with_hold_timer.sv -----
// ----------------------------------------------------------------------------
// Testbench for the button debouncer with hold timer
// Drives timer ticks through the valid/stall tick channel with bursts and
// gaps, stalls the result channel on a pattern of its own, and checks every
// result request field by field against a cycle-free model of the debouncer.
// The run moves through directed cases, a long hold with the widest interval,
// and randomised press sequences under several register settings.
// ----------------------------------------------------------------------------
module tb_button_debouncer_with_hold_timer;

  // One tick request as it waits in the driver queue.
  typedef struct packed {
    logic pin;
    logic clr;
  } tick_t;

  // Receiver behaviour on the result channel.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_RUNS
  } stall_mode_e;

  logic                         clk_i;
  logic                         rst_n       = 1'b0;
  logic                         cfg_we      = 1'b0;
  logic [1:0]                   cfg_idx     = bdh_pkg::CFG_ACTIVE_HIGH;
  logic [bdh_pkg::CfgDataW-1:0] cfg_wdata   = '0;
  logic                         tick_valid  = 1'b0;
  logic                         pin_level   = 1'b0;
  logic                         clear_click = 1'b0;
  logic                         result_stall = 1'b0;

  logic                         tick_stall;
  logic                         result_valid;
  logic                         pressed;
  logic                         press_event;
  logic                         release_event;
  logic                         change_event;
  logic                         clicked;
  logic [bdh_pkg::OutW-1:0]     time_in_state;
  logic [bdh_pkg::OutW-1:0]     time_in_last_state;

  button_debouncer_with_hold_timer u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_idx_i           (cfg_idx),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (tick_valid),
    .in_stall_o          (tick_stall),
    .pin_level_i         (pin_level),
    .clear_click_i       (clear_click),
    .out_valid_o         (result_valid),
    .out_stall_i         (result_stall),
    .pressed_o           (pressed),
    .press_event_o       (press_event),
    .release_event_o     (release_event),
    .change_event_o      (change_event),
    .clicked_o           (clicked),
    .time_in_state_o     (time_in_state),
    .time_in_last_state_o(time_in_last_state)
  );

  // Ticks waiting to be sent, and the results that accepted ticks must yield.
  tick_t            tick_q[$];
  bdh_pkg::result_t pending_results[$];
  int               err_cnt = 0;

  // Debouncer model: its own copy of the registers and of the state.
  bdh_pkg::cfg_t db_cfg = '{active_high:   bdh_pkg::RstActiveHigh,
                            tick_interval: bdh_pkg::RstTickInterval,
                            min_hold_time: bdh_pkg::RstMinHoldTime,
                            max_count:     bdh_pkg::RstMaxCount};
  logic          db_raw      = 1'b0;
  logic          db_stable   = 1'b0;
  bdh_pkg::cnt_t db_hold     = '0;
  bdh_pkg::cnt_t db_last_dur = '0;
  logic          db_click    = 1'b0;

  // Sender burst shaping and receiver stall pattern.
  int          burst_left = 0;
  int          gap_left   = 0;
  int          stall_cycle = 0;
  int          stall_run  = 0;
  stall_mode_e stall_mode = STALL_NONE;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Generous ceiling on the whole run, well above the slowest legal run.
  initial begin
    #60_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    err_cnt++;
  endtask

  // Advances the model by one accepted tick and queues the result it yields.
  // The add saturates at the counter width; the debounce compare sees the
  // count after the add, and only then is the count clamped to the ceiling.
  task automatic debounce_tick(input logic pin, input logic clr);
    logic                   raw;
    logic [bdh_pkg::CntW:0] sum;
    logic [bdh_pkg::CntW:0] step_v;
    bdh_pkg::cnt_t          minh;
    bdh_pkg::cnt_t          ceil_v;
    bdh_pkg::cnt_t          tis;
    bdh_pkg::result_t       r;
    raw    = db_cfg.active_high ? pin : ~pin;
    minh   = bdh_pkg::cnt_t'(db_cfg.min_hold_time);
    ceil_v = bdh_pkg::cnt_t'(db_cfg.max_count);
    step_v = '0;
    step_v[bdh_pkg::TickW-1:0] = db_cfg.tick_interval;
    r = '0;
    if (raw == db_raw) begin
      sum = {1'b0, db_hold} + step_v;
      db_hold = sum[bdh_pkg::CntW] ? '1 : sum[bdh_pkg::CntW-1:0];
    end else begin
      // A raw change keeps the old count only if it outlasted the minimum.
      if (db_hold > minh) db_last_dur = db_hold;
      db_hold = '0;
      db_raw  = raw;
    end
    if (db_hold >= minh && db_stable != db_raw) begin
      r.change_event = 1'b1;
      db_stable = db_raw;
      if (db_stable) begin
        r.press_event = 1'b1;
      end else begin
        r.release_event = 1'b1;
        db_click = 1'b1;
      end
    end
    if (db_hold >= ceil_v) db_hold = ceil_v;
    tis = (db_hold > minh) ? db_hold - minh : '0;
    r.pressed            = db_stable;
    r.clicked            = db_click;
    r.time_in_state      = tis;
    r.time_in_last_state = db_last_dur;
    pending_results.push_back(r);
    // The flag is reported first and only then cleared.
    if (clr) db_click = 1'b0;
  endtask

  // Driver: takes ticks from the queue in bursts, with random gaps between
  // them. A request stays put, payload and all, for as long as it is stalled.
  always @(posedge clk_i) begin
    tick_t nxt;
    logic  take;
    if (!rst_n) begin
      tick_valid <= 1'b0;
    end else begin
      take = tick_valid && !tick_stall;
      if (take) debounce_tick(pin_level, clear_click);
      if (!tick_valid || take) begin
        if (gap_left > 0) begin
          gap_left--;
          tick_valid  <= 1'b0;
          // Idle payload is junk; the block must not look at it.
          pin_level   <= 1'($urandom);
          clear_click <= 1'($urandom);
        end else if (tick_q.size() > 0) begin
          nxt = tick_q.pop_front();
          tick_valid  <= 1'b1;
          pin_level   <= nxt.pin;
          clear_click <= nxt.clr;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          tick_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: the mode changes every so often, so that there
  // are stretches with no stall, scattered stalls, and long runs of stall.
  always @(posedge clk_i) begin
    logic nxt_stall;
    if (!rst_n) begin
      result_stall <= 1'b0;
    end else begin
      stall_cycle++;
      if (stall_cycle % 97 == 0) stall_mode = stall_mode_e'($urandom_range(0, 2));
      nxt_stall = 1'b0;
      case (stall_mode)
        STALL_RANDOM: begin
          nxt_stall = ($urandom_range(0, 2) == 0);
        end
        STALL_RUNS: begin
          if (stall_run > 0) begin
            stall_run--;
            nxt_stall = 1'b1;
          end else if ($urandom_range(0, 9) == 0) begin
            stall_run = $urandom_range(1, 8);
            nxt_stall = 1'b1;
          end
        end
        default: nxt_stall = 1'b0;
      endcase
      result_stall <= nxt_stall;
    end
  end

  // Monitor: every accepted result request is matched with the oldest
  // prediction.
  always @(posedge clk_i) begin
    bdh_pkg::result_t got;
    bdh_pkg::result_t want;
    if (rst_n && result_valid && !result_stall) begin
      got = {pressed, press_event, release_event, change_event, clicked,
             time_in_state, time_in_last_state};
      if (pending_results.size() == 0) begin
        report_mismatch("result with no tick pending", 32'(got.time_in_state), '0);
      end else begin
        want = pending_results.pop_front();
        if (got.pressed != want.pressed)
          report_mismatch("pressed", 32'(got.pressed), 32'(want.pressed));
        if (got.press_event != want.press_event)
          report_mismatch("press_event", 32'(got.press_event), 32'(want.press_event));
        if (got.release_event != want.release_event)
          report_mismatch("release_event", 32'(got.release_event),
                          32'(want.release_event));
        if (got.change_event != want.change_event)
          report_mismatch("change_event", 32'(got.change_event), 32'(want.change_event));
        if (got.clicked != want.clicked)
          report_mismatch("clicked", 32'(got.clicked), 32'(want.clicked));
        if (got.time_in_state != want.time_in_state)
          report_mismatch("time_in_state", 32'(got.time_in_state),
                          32'(want.time_in_state));
        if (got.time_in_last_state != want.time_in_last_state)
          report_mismatch("time_in_last_state", 32'(got.time_in_last_state),
                          32'(want.time_in_last_state));
      end
    end
  end

  task automatic push_tick(logic pin, logic clr);
    tick_q.push_back('{pin: pin, clr: clr});
  endtask

  // Blocks until every queued tick has been sent and every result has come
  // back, then lets the result register settle.
  task automatic wait_idle();
    while (tick_q.size() != 0 || tick_valid || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // One register write; the model takes the value once the edge has passed.
  task automatic write_reg(bdh_pkg::cfg_idx_e idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      bdh_pkg::CFG_ACTIVE_HIGH:   db_cfg.active_high   = data[0];
      bdh_pkg::CFG_TICK_INTERVAL: db_cfg.tick_interval = data[bdh_pkg::TickW-1:0];
      bdh_pkg::CFG_MIN_HOLD_TIME: db_cfg.min_hold_time = data;
      bdh_pkg::CFG_MAX_COUNT:     db_cfg.max_count     = data;
      default: ;
    endcase
  endtask

  // Writes all four registers. The narrow ones carry junk in their unused
  // upper bits, which the block must discard.
  task automatic apply_config(logic act, logic [15:0] tick, logic [31:0] minh,
                              logic [31:0] maxc);
    write_reg(bdh_pkg::CFG_ACTIVE_HIGH, {31'($urandom), act});
    write_reg(bdh_pkg::CFG_TICK_INTERVAL, {16'($urandom), tick});
    write_reg(bdh_pkg::CFG_MIN_HOLD_TIME, minh);
    write_reg(bdh_pkg::CFG_MAX_COUNT, maxc);
  endtask

  // Queues button activity: mostly runs of one level long enough to pass
  // the minimum hold, broken now and then by short bouncing noise.
  task automatic add_presses(int n);
    int   made;
    int   run_len;
    logic lvl;
    made = 0;
    lvl  = 1'($urandom);
    while (made < n) begin
      if ($urandom_range(0, 4) == 0) begin
        run_len = $urandom_range(1, 4);
        repeat (run_len) push_tick(1'($urandom), 1'($urandom));
      end else begin
        run_len = $urandom_range(1, 12);
        repeat (run_len) push_tick(lvl, ($urandom_range(0, 3) == 0));
        lvl = ~lvl;
      end
      made += run_len;
    end
  endtask

  initial begin
    logic        act;
    logic [15:0] tick;
    logic [31:0] minh;
    logic [31:0] maxc;

    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;

    // Reset registers: low level means pressed, so a low pin is a raw change.
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b1);
    wait_idle();

    // Short minimum hold with a low ceiling: press, clamp at the ceiling,
    // a stored duration, a glitch too short to be stored, then a release
    // with the clear on the very same tick.
    apply_config(1'b1, 16'd1, 32'd2, 32'd5);
    repeat (6) push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b0);
    wait_idle();

    // Zero minimum hold: the debounced state follows the raw level at once.
    apply_config(1'b1, 16'd1, 32'd0, 32'd5);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b0);
    wait_idle();

    // Long hold with the widest interval: the count climbs in large steps
    // well past the minimum hold, and the long duration is then stored.
    apply_config(1'b1, 16'hFFFF, 32'd1_000_000, 32'hFFFF_FFFF);
    repeat (100) push_tick(1'b1, 1'b0);
    repeat (3) push_tick(1'b0, 1'b0);
    wait_idle();

    // Random settings, extremes among them, each with fresh press traffic.
    for (int p = 0; p < 10; p++) begin
      act = 1'($urandom);
      case ($urandom_range(0, 9))
        0:       tick = 16'd0;
        1:       tick = 16'hFFFF;
        default: tick = 16'($urandom_range(1, 3));
      endcase
      case ($urandom_range(0, 9))
        0:       minh = 32'd0;
        1:       minh = 32'hFFFF_FFFF;
        default: minh = $urandom_range(0, 8);
      endcase
      case ($urandom_range(0, 5))
        0:       maxc = 32'd0;
        1:       maxc = 32'hFFFF_FFFF;
        2:       maxc = $urandom_range(0, 20);
        default: maxc = $urandom;
      endcase
      apply_config(act, tick, minh, maxc);
      add_presses(38);
      wait_idle();
    end

    repeat (5) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 32'(pending_results.size()), '0);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
